// File: src/arkf_pkg.sv
package arkf_pkg;

  localparam int unsigned CFG_ADDR_W = 4;

  // covariance, gain and time step fraction bits
  localparam int COV_FRAC_BITS = 24;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

  localparam logic [31:0] ANGLE_NOISE_RST = 32'd16777;
  localparam logic [31:0] BIAS_NOISE_RST  = 32'd50332;
  localparam logic [31:0] MEAS_NOISE_RST  = 32'd503316;

  // datapath step codes
  typedef enum logic [4:0] {
    SP_NOP, SP_SETA, SP_RATE,
    SP_M1, SP_A1, SP_M2, SP_A2, SP_M3, SP_A3, SP_M4, SP_A4,
    SP_DIV0, SP_DIV1, SP_DRUN, SP_K0, SP_K1, SP_KZERO, SP_Y,
    SP_M5, SP_A5, SP_M6, SP_A6, SP_M7, SP_A7, SP_M8, SP_A8,
    SP_M9, SP_A9, SP_M10, SP_A10
  } step_t;

  typedef struct packed {
    step_t step;
    logic  load_in;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic s_pos;
    logic div_done;
  } sts_t;

endpackage

// File: src/arkf_ctrl.sv
module arkf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           action,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  arkf_pkg::sts_t sts,
  output arkf_pkg::cmd_t cmd
);
  import arkf_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIVW, ST_FIN} state_t;

  state_t state;
  step_t  step;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd.load_in  = accept;
    cmd.load_out = (state == ST_FIN) && out_free;
    case (state)
      ST_RUN:  cmd.step = step;
      ST_DIVW: cmd.step = SP_DRUN;
      default: cmd.step = SP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= SP_NOP;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
            step  <= action ? SP_SETA : SP_RATE;
          end
        end
        ST_RUN: begin
          case (step)
            SP_RATE:  step <= SP_M1;
            SP_M1:    step <= SP_A1;
            SP_A1:    step <= SP_M2;
            SP_M2:    step <= SP_A2;
            SP_A2:    step <= SP_M3;
            SP_M3:    step <= SP_A3;
            SP_A3:    step <= SP_M4;
            SP_M4:    step <= SP_A4;
            SP_A4:    step <= SP_DIV0;
            SP_DIV0, SP_DIV1: begin
              if (sts.s_pos) state <= ST_DIVW;
              else step <= SP_KZERO;
            end
            SP_K0:    step <= SP_DIV1;
            SP_K1:    step <= SP_Y;
            SP_KZERO: step <= SP_Y;
            SP_Y:     step <= SP_M5;
            SP_M5:    step <= SP_A5;
            SP_A5:    step <= SP_M6;
            SP_M6:    step <= SP_A6;
            SP_A6:    step <= SP_M7;
            SP_M7:    step <= SP_A7;
            SP_A7:    step <= SP_M8;
            SP_M8:    step <= SP_A8;
            SP_A8:    step <= SP_M9;
            SP_M9:    step <= SP_A9;
            SP_A9:    step <= SP_M10;
            SP_M10:   step <= SP_A10;
            default:  state <= ST_FIN;
          endcase
        end
        ST_DIVW: begin
          if (sts.div_done) begin
            state <= ST_RUN;
            step  <= (step == SP_DIV0) ? SP_K0 : SP_K1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/arkf_datapath.sv
module arkf_datapath #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  arkf_pkg::cmd_t      cmd,
  output arkf_pkg::sts_t      sts,
  input  logic signed [25:0]  measured_angle,
  input  logic signed [27:0]  gyro_rate,
  input  logic        [23:0]  time_step,
  input  logic        [31:0]  angle_noise,
  input  logic        [31:0]  bias_noise,
  input  logic        [31:0]  meas_noise,
  output logic signed [25:0]  angle_estimate,
  output logic signed [27:0]  unbiased_rate
);
  import arkf_pkg::*;

  localparam logic signed [68:0] HALF = 69'sd1 <<< (COV_FRAC_BITS - 1);
  localparam longint LIM_A_RAW = 360 * (64'sd1 <<< ANGLE_FRAC_BITS);
  localparam longint LIM_R_RAW = 2000 * (64'sd1 <<< ANGLE_FRAC_BITS);
  localparam logic signed [31:0] LIM_A =
    32'((LIM_A_RAW > 33554431) ? 33554431 : LIM_A_RAW);
  localparam logic signed [31:0] LIM_R =
    32'((LIM_R_RAW > 134217727) ? 134217727 : LIM_R_RAW);
  localparam logic [6:0] DIV_STEPS = 7'd64;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'sh7fffffff;
    if (v < -48'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [25:0] meas_q;
  logic signed [27:0] gyro_q;
  logic        [23:0] dt_q;

  logic signed [31:0] angle, bias, rate, aa, ab, ba, bb;
  logic signed [32:0] dtp11;
  logic signed [35:0] t;
  logic signed [33:0] s;
  logic signed [31:0] k0, k1, y, p00, p01;

  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] prod;
  logic signed [68:0] rsum;
  logic signed [68:0] rshift;
  logic signed [44:0] rnd;

  // restoring divider, one quotient bit a cycle
  logic        [33:0] rem;
  logic        [63:0] dq;
  logic        [33:0] dsor;
  logic        [6:0]  dcnt;
  logic               dneg;
  logic        [34:0] dshift;
  logic        [34:0] dtrial;
  logic        [32:0] dmag;
  logic signed [31:0] qsat;

  logic signed [32:0] dt33;
  assign dt33 = $signed({9'd0, dt_q});

  assign rsum   = prod + HALF;
  assign rshift = rsum >>> COV_FRAC_BITS;
  assign rnd    = rshift[44:0];

  assign sts.s_pos    = !s[33] && (s != 34'sd0);
  assign sts.div_done = (dcnt == DIV_STEPS);

  assign dshift = {rem, dq[63]};
  assign dtrial = dshift - {1'b0, dsor};

  always_comb begin
    if (cmd.step == SP_DIV1) dmag = ba[31] ? -33'(ba) : 33'(ba);
    else                     dmag = aa[31] ? -33'(aa) : 33'(aa);
  end

  always_comb begin
    if (|dq[63:31])  qsat = dneg ? 32'sh80000000 : 32'sh7fffffff;
    else if (dneg)   qsat = -$signed(dq[31:0]);
    else             qsat = $signed(dq[31:0]);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      SP_M1:   begin mul_a = 36'(rate); mul_b = dt33; end
      SP_M2:   begin mul_a = 36'(bb);   mul_b = dt33; end
      SP_M3:   begin mul_a = t;         mul_b = dt33; end
      SP_M4:   begin mul_a = $signed({4'd0, bias_noise}); mul_b = dt33; end
      SP_M5:   begin mul_a = 36'(y);    mul_b = 33'(k0); end
      SP_M6:   begin mul_a = 36'(y);    mul_b = 33'(k1); end
      SP_M7:   begin mul_a = 36'(p00);  mul_b = 33'(k0); end
      SP_M8:   begin mul_a = 36'(p01);  mul_b = 33'(k0); end
      SP_M9:   begin mul_a = 36'(p00);  mul_b = 33'(k1); end
      SP_M10:  begin mul_a = 36'(p01);  mul_b = 33'(k1); end
      default: begin mul_a = '0;        mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load_in) begin
      meas_q <= measured_angle;
      gyro_q <= gyro_rate;
      dt_q   <= time_step;
    end
    if (cmd.load_out) begin
      if (angle > LIM_A)       angle_estimate <= LIM_A[25:0];
      else if (angle < -LIM_A) angle_estimate <= 26'(-LIM_A);
      else                     angle_estimate <= angle[25:0];
      if (rate > LIM_R)        unbiased_rate <= LIM_R[27:0];
      else if (rate < -LIM_R)  unbiased_rate <= 28'(-LIM_R);
      else                     unbiased_rate <= rate[27:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      bias  <= '0;
      rate  <= '0;
      aa    <= '0;
      ab    <= '0;
      ba    <= '0;
      bb    <= '0;
      dcnt  <= DIV_STEPS;
      s     <= '0;
    end else begin
      case (cmd.step)
        SP_SETA: angle <= 32'(meas_q);
        SP_RATE: rate  <= sat32(48'(gyro_q) - 48'(bias));
        SP_A1:   angle <= sat32(48'(angle) + 48'(rnd));
        SP_A2: begin
          dtp11 <= rnd[32:0];
          t     <= 36'(rnd) - 36'(ab) - 36'(ba) + $signed({4'd0, angle_noise});
        end
        SP_A3: begin
          aa <= sat32(48'(aa) + 48'(rnd));
          ab <= sat32(48'(ab) - 48'(dtp11));
          ba <= sat32(48'(ba) - 48'(dtp11));
        end
        SP_A4: begin
          bb <= sat32(48'(bb) + 48'(rnd));
          s  <= 34'(aa) + $signed({2'd0, meas_noise});
        end
        SP_DIV0, SP_DIV1: begin
          dneg <= (cmd.step == SP_DIV1) ? ba[31] : aa[31];
          dq   <= {31'd0, dmag} << COV_FRAC_BITS;
          rem  <= '0;
          dsor <= s;
          dcnt <= '0;
        end
        SP_DRUN: begin
          if (dcnt != DIV_STEPS) begin
            if (!dtrial[34]) begin
              rem <= dtrial[33:0];
              dq  <= {dq[62:0], 1'b1};
            end else begin
              rem <= dshift[33:0];
              dq  <= {dq[62:0], 1'b0};
            end
            dcnt <= dcnt + 7'd1;
          end
        end
        SP_K0:    k0 <= qsat;
        SP_K1:    k1 <= qsat;
        SP_KZERO: begin
          k0 <= '0;
          k1 <= '0;
        end
        SP_Y: begin
          y   <= sat32(48'(meas_q) - 48'(angle));
          p00 <= aa;
          p01 <= ab;
        end
        SP_A5:   angle <= sat32(48'(angle) + 48'(rnd));
        SP_A6:   bias  <= sat32(48'(bias) + 48'(rnd));
        SP_A7:   aa    <= sat32(48'(aa) - 48'(rnd));
        SP_A8:   ab    <= sat32(48'(ab) - 48'(rnd));
        SP_A9:   ba    <= sat32(48'(ba) - 48'(rnd));
        SP_A10:  bb    <= sat32(48'(bb) - 48'(rnd));
        default: ;
      endcase
    end
  end

endmodule

// File: src/angle_rate_kalman_filter.sv
// channel  | valid / stall        | payload
// input    | in_valid / in_stall  | action, measured_angle, gyro_rate, time_step
// output   | out_valid / out_stall| angle_estimate, unbiased_rate
// config   | apb psel/penable     | paddr, pwdata, prdata (noise registers)
// update beat: two 64-step gain divisions, all other steps one step a cycle
// on one shared multiplier
// an update whose innovation variance is not positive skips both divisions
// set-angle beat loads the measured angle; one beat is in work at a time
// synchronous reset clears the filter state and loads the default noise terms
// a finished result waits in the output register; out_stall holds it there
module angle_rate_kalman_filter #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic signed [25:0]              measured_angle,
  input  logic signed [27:0]              gyro_rate,
  input  logic        [23:0]              time_step,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [25:0]              angle_estimate,
  output logic signed [27:0]              unbiased_rate,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arkf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import arkf_pkg::*;

  logic [31:0] angle_noise;
  logic [31:0] bias_noise;
  logic [31:0] meas_noise;
  logic        cfg_wr;
  cmd_t        cmd;
  sts_t        sts;

  // registers sit at word addresses, index in paddr[3:2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise <= ANGLE_NOISE_RST;
      bias_noise  <= BIAS_NOISE_RST;
      meas_noise  <= MEAS_NOISE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ANGLE_NOISE: angle_noise <= pwdata;
        REG_BIAS_NOISE:  bias_noise  <= pwdata;
        REG_MEAS_NOISE:  meas_noise  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ANGLE_NOISE: prdata = angle_noise;
      REG_BIAS_NOISE:  prdata = bias_noise;
      REG_MEAS_NOISE:  prdata = meas_noise;
      default:         prdata = 32'd0;
    endcase
  end

  // sequencer: walks the step list, waits on the divider
  arkf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // filter state, shared multiplier, gain divider, output register
  arkf_datapath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .measured_angle (measured_angle),
    .gyro_rate      (gyro_rate),
    .time_step      (time_step),
    .angle_noise    (angle_noise),
    .bias_noise     (bias_noise),
    .meas_noise     (meas_noise),
    .angle_estimate (angle_estimate),
    .unbiased_rate  (unbiased_rate)
  );

endmodule

// File: src/arkf_checker.sv
module arkf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [25:0] angle_estimate,
  input logic [27:0] unbiased_rate
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle_estimate) &&
      $stable(unbiased_rate))
    else $error("stalled result beat changed");

  // an accepted beat makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a result appears only from a busy block
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work in progress");

  // reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind angle_rate_kalman_filter arkf_checker u_arkf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .angle_estimate (angle_estimate),
  .unbiased_rate  (unbiased_rate)
);
